@@ sv/laq_pkg.sv @@
// Shared constants, codes and types for the look-at quaternion unit.
// No dependencies; compiled first.
package laq_pkg;

  localparam int QF        = 14;             // fraction bits of Q2.14
  localparam int ONE       = 1 << QF;
  localparam int PW        = 32;             // point coordinate width
  localparam int DW        = PW + 1;         // difference width
  localparam int AW        = 30;             // scaled magnitude width
  localparam int NW        = AW + 1;         // norm root bits
  localparam int QW        = QF + 1;         // unit component quotient bits
  localparam int RMW       = AW + QF + 2;    // divider remainder width
  localparam int UW        = 16;             // unit / quaternion width
  localparam int RTW       = QF + 1;         // half-angle root bits
  localparam int TW        = 10;             // tolerance width
  localparam int NORM_LAT  = 6 + NW + 1 + QW + 1;
  localparam int SIDE_LAT  = 2 + RTW + 1;
  localparam int SIDE_DLY  = NORM_LAT - SIDE_LAT;
  localparam int TOTAL_LAT = 1 + NORM_LAT + 2 + NORM_LAT + 2;
  localparam int CFG_IW    = 3;
  localparam int CFG_DW    = 16;

  typedef enum logic [CFG_IW-1:0] {
    REG_FWD_X, REG_FWD_Y, REG_FWD_Z, REG_UP_X, REG_UP_Y, REG_UP_Z, REG_TOL
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CODE_GENERAL, CODE_ALIGNED, CODE_OPPOSITE, CODE_DEGEN
  } case_code_t;

  typedef struct packed {
    logic           nz;
    logic           opp;
    logic           ali;
    logic           cpos;
    logic [RTW-1:0] w;
    logic [RTW-1:0] s;
  } side_t;

endpackage

@@ sv/laq_ifs.sv @@
// Valid/ready channel interfaces for point pairs in and quaternions out.
// Depends on laq_pkg.
interface laq_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [laq_pkg::PW-1:0]  src_x, src_y, src_z;
  logic signed [laq_pkg::PW-1:0]  dst_x, dst_y, dst_z;

  modport source (output valid, src_x, src_y, src_z, dst_x, dst_y, dst_z, input ready);
  modport sink   (input valid, src_x, src_y, src_z, dst_x, dst_y, dst_z, output ready);
endinterface

interface laq_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [laq_pkg::UW-1:0]  quat_w, quat_x, quat_y, quat_z;
  logic [1:0]                     case_code;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, case_code, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, case_code, output ready);
endinterface

@@ sv/laq_sqrt_cell.sv @@
// One bit step of a restoring integer square root, registered.
// Cells chain to give floor root and remainder. Depends on nothing.
module laq_sqrt_cell #(
  parameter int RW = 31
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] x_i,
  input  logic [RW+1:0]   r_i,
  input  logic [RW-1:0]   q_i,
  output logic [2*RW-1:0] x_o,
  output logic [RW+1:0]   r_o,
  output logic [RW-1:0]   q_o
);

  logic [RW+3:0]   rr, t;
  logic [2*RW-1:0] x_nxt, x_r;
  logic [RW+1:0]   r_nxt, r_r;
  logic [RW-1:0]   q_nxt, q_r;

  always_comb begin
    rr    = {r_i, x_i[2*RW-1 -: 2]};
    t     = {2'b00, q_i, 2'b01};
    x_nxt = {x_i[2*RW-3:0], 2'b00};
    if (rr >= t) begin
      r_nxt = (RW+2)'(rr - t);
      q_nxt = {q_i[RW-2:0], 1'b1};
    end else begin
      r_nxt = (RW+2)'(rr);
      q_nxt = {q_i[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      r_r <= r_nxt;
      q_r <= q_nxt;
    end
  end

  assign x_o = x_r;
  assign r_o = r_r;
  assign q_o = q_r;

endmodule

@@ sv/laq_div_cell.sv @@
// One quotient bit of a restoring divide for three lanes sharing a divisor.
// Depends on laq_pkg.
module laq_div_cell #(
  parameter int K = 0
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [laq_pkg::NW-1:0]    n_i,
  input  logic [laq_pkg::RMW-1:0]   rem_i [3],
  input  logic [laq_pkg::QW-1:0]    q_i   [3],
  output logic [laq_pkg::NW-1:0]    n_o,
  output logic [laq_pkg::RMW-1:0]   rem_o [3],
  output logic [laq_pkg::QW-1:0]    q_o   [3]
);
  import laq_pkg::*;

  logic [RMW-1:0] dv;
  logic [RMW-1:0] rem_nxt [3];
  logic [QW-1:0]  q_nxt   [3];
  logic [RMW-1:0] rem_r   [3];
  logic [QW-1:0]  q_r     [3];
  logic [NW-1:0]  n_r;

  always_comb begin
    dv = RMW'(n_i) << K;
    for (int i = 0; i < 3; i++) begin
      q_nxt[i] = q_i[i];
      if (rem_i[i] >= dv) begin
        rem_nxt[i]  = rem_i[i] - dv;
        q_nxt[i][K] = 1'b1;
      end else begin
        rem_nxt[i] = rem_i[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_i;
      for (int i = 0; i < 3; i++) begin
        rem_r[i] <= rem_nxt[i];
        q_r[i]   <= q_nxt[i];
      end
    end
  end

  assign n_o   = n_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;

endmodule

@@ sv/laq_norm.sv @@
// Vector normaliser: scales magnitudes, takes the norm by a root cell chain
// and divides each component by it in a divide cell chain, to Q2.14.
// Depends on laq_pkg, laq_sqrt_cell and laq_div_cell.
module laq_norm (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [laq_pkg::DW-1:0]  v_i [3],
  output logic signed [laq_pkg::UW-1:0]  u_o [3],
  output logic                           nz_o
);
  import laq_pkg::*;

  localparam int TOP = AW - 1;

  typedef struct packed {
    logic [2:0][AW-1:0] a;
    logic [2:0]         neg;
    logic               nz;
  } nln_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       nz;
  } sgn_t;

  logic [DW-1:0]   mag_a_r [3], mag_b_r [3], mag_c_r [3];
  logic [2:0]      neg_a_r, neg_b_r, neg_c_r;
  logic [DW-1:0]   mx_nxt, mx_b_r;
  logic [5:0]      p_nxt, p_c_r;
  logic            nz_c_r;
  nln_t            d_nxt, d_r;
  logic [2*AW-1:0] sq_r [3];
  logic [2*NW-1:0] sum_r;
  nln_t            ln1_r [NW+2];

  logic [2*NW-1:0] sx [NW+1];
  logic [NW+1:0]   sr [NW+1];
  logic [NW-1:0]   sq [NW+1];

  logic [RMW-1:0]  num_r [3];
  logic [NW-1:0]   n_g_r;
  sgn_t            g_r;
  sgn_t            ln2_r [QW];

  logic [NW-1:0]   dn  [QW+1];
  logic [RMW-1:0]  drm [QW+1][3];
  logic [QW-1:0]   dq  [QW+1][3];

  logic signed [UW-1:0] u_r [3];
  logic                 nz_r;

  always_comb begin
    mx_nxt = mag_a_r[0];
    if (mag_a_r[1] > mx_nxt) mx_nxt = mag_a_r[1];
    if (mag_a_r[2] > mx_nxt) mx_nxt = mag_a_r[2];
  end

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < DW; i++) begin
      if (mx_b_r[i]) p_nxt = 6'(i);
    end
  end

  // bring the largest magnitude into [2^29, 2^30); right shifts truncate
  always_comb begin
    d_nxt.neg = neg_c_r;
    d_nxt.nz  = nz_c_r;
    for (int i = 0; i < 3; i++) begin
      if (p_c_r > 6'(TOP)) d_nxt.a[i] = AW'(mag_c_r[i] >> (p_c_r - 6'(TOP)));
      else                 d_nxt.a[i] = AW'(mag_c_r[i] << (6'(TOP) - p_c_r));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_a_r[i] <= v_i[i][DW-1] ? DW'(-v_i[i]) : DW'(v_i[i]);
        neg_a_r[i] <= v_i[i][DW-1];
        mag_b_r[i] <= mag_a_r[i];
        mag_c_r[i] <= mag_b_r[i];
        sq_r[i]    <= d_r.a[i] * d_r.a[i];
      end
      neg_b_r <= neg_a_r;
      neg_c_r <= neg_b_r;
      mx_b_r  <= mx_nxt;
      p_c_r   <= p_nxt;
      nz_c_r  <= (mx_b_r != '0);
      d_r     <= d_nxt;
      sum_r   <= (2*NW)'(sq_r[0]) + (2*NW)'(sq_r[1]) + (2*NW)'(sq_r[2]);
      ln1_r[0] <= d_r;
      for (int k = 1; k < NW+2; k++) ln1_r[k] <= ln1_r[k-1];
    end
  end

  assign sx[0] = sum_r;
  assign sr[0] = '0;
  assign sq[0] = '0;

  for (genvar c = 0; c < NW; c++) begin : g_sqrt
    laq_sqrt_cell #(.RW(NW)) u_cell (
      .clk (clk), .en (en),
      .x_i (sx[c]),   .r_i (sr[c]),   .q_i (sq[c]),
      .x_o (sx[c+1]), .r_o (sr[c+1]), .q_o (sq[c+1])
    );
  end

  // numerators carry half the norm so the divide rounds to nearest
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (RMW'(ln1_r[NW+1].a[i]) << QF) + RMW'(sq[NW] >> 1);
      end
      n_g_r    <= sq[NW];
      g_r.neg  <= ln1_r[NW+1].neg;
      g_r.nz   <= ln1_r[NW+1].nz;
      ln2_r[0] <= g_r;
      for (int k = 1; k < QW; k++) ln2_r[k] <= ln2_r[k-1];
    end
  end

  assign dn[0] = n_g_r;
  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign drm[0][i] = num_r[i];
    assign dq[0][i]  = '0;
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    laq_div_cell #(.K(QW-1-j)) u_cell (
      .clk   (clk), .en (en),
      .n_i   (dn[j]),   .rem_i (drm[j]),   .q_i (dq[j]),
      .n_o   (dn[j+1]), .rem_o (drm[j+1]), .q_o (dq[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= ln2_r[QW-1].neg[i] ? -$signed({1'b0, dq[QW][i]})
                                     :  $signed({1'b0, dq[QW][i]});
      end
      nz_r <= ln2_r[QW-1].nz;
    end
  end

  assign u_o  = u_r;
  assign nz_o = nz_r;

endmodule

@@ sv/look_at_quaternion_unit.sv @@
// Channel   | Dir | Handshake     | Payload
// in_ch     | in  | valid / ready | src_x..z, dst_x..z (Q16.16)
// out_ch    | out | valid / ready | quat_w..z (Q2.14), case_code
// cfg_*     | in  | cfg_we        | cfg_idx, cfg_wdata
//
// One point pair per cycle while not stalled; the two normalisers run in series
// (each a 31-cell root chain and a 15-cell divide chain).
// Synchronous active-low reset clears valid bits and restores configuration defaults only.
// While a result sits unaccepted, every stage holds and in_ch.ready is low.
// Depends on laq_pkg, laq_ifs, laq_norm, laq_sqrt_cell.
module look_at_quaternion_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  laq_in_if.sink                      in_ch,
  laq_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [laq_pkg::CFG_IW-1:0]  cfg_idx,
  input  logic [laq_pkg::CFG_DW-1:0]  cfg_wdata
);
  import laq_pkg::*;

  localparam logic signed [19:0] DOT_ONE = 20'(ONE);

  logic signed [UW-1:0] fwd_r [3];
  logic signed [UW-1:0] up_r  [3];
  logic [TW-1:0]        tol_r;

  logic                 en;
  logic                 v_r [TOTAL_LAT];

  logic signed [DW-1:0] d_r [3];
  logic signed [UW-1:0] u1 [3];
  logic                 nz1;
  logic signed [31:0]   pf_r [3];
  logic signed [31:0]   pc_r [6];
  logic                 nz_t1_r;
  logic signed [33:0]   dsum_r;
  logic signed [DW-1:0] cr_r [3];
  logic                 nz_t2_r;
  logic signed [UW-1:0] ax [3];
  logic                 nz2;

  logic [33:0]          dmag;
  logic [19:0]          dm2;
  logic signed [19:0]   dot_r;
  logic                 nz_t3_r;

  logic signed [20:0]   dp, dn;
  logic [20:0]          dpa, dna;
  logic signed [UW-1:0] c_nxt;
  logic [UW-1:0]        opc, omc;
  logic [2*RTW-1:0]     xw_r, xs_r;
  side_t                fl_nxt, fl_r;
  side_t                fl_ln_r [RTW];

  logic [2*RTW-1:0]     wx [RTW+1], sx [RTW+1];
  logic [RTW+1:0]       wr [RTW+1], sr [RTW+1];
  logic [RTW-1:0]       wq [RTW+1], sq [RTW+1];

  side_t                side_nxt, side_r;
  side_t                sd_r [SIDE_DLY];
  side_t                sd_out;

  logic signed [31:0]   pq_r [3];
  logic [RTW-1:0]       w_p_r;
  case_code_t           code_nxt, code_p_r;

  logic [31:0]          pmag [3];
  logic [UW-1:0]        pm2  [3];
  logic signed [UW-1:0] qv_nxt [4];
  logic signed [UW-1:0] qv_r [4];
  case_code_t           code_o_r;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r[0] <= 16'(ONE);
      fwd_r[1] <= '0;
      fwd_r[2] <= '0;
      up_r[0]  <= '0;
      up_r[1]  <= '0;
      up_r[2]  <= 16'(ONE);
      tol_r    <= TW'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_FWD_X: fwd_r[0] <= cfg_wdata;
        REG_FWD_Y: fwd_r[1] <= cfg_wdata;
        REG_FWD_Z: fwd_r[2] <= cfg_wdata;
        REG_UP_X:  up_r[0]  <= cfg_wdata;
        REG_UP_Y:  up_r[1]  <= cfg_wdata;
        REG_UP_Z:  up_r[2]  <= cfg_wdata;
        REG_TOL:   tol_r    <= cfg_wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TOTAL_LAT; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_ch.valid;
      for (int k = 1; k < TOTAL_LAT; k++) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= $signed({in_ch.dst_x[PW-1], in_ch.dst_x}) - $signed({in_ch.src_x[PW-1], in_ch.src_x});
      d_r[1] <= $signed({in_ch.dst_y[PW-1], in_ch.dst_y}) - $signed({in_ch.src_y[PW-1], in_ch.src_y});
      d_r[2] <= $signed({in_ch.dst_z[PW-1], in_ch.dst_z}) - $signed({in_ch.src_z[PW-1], in_ch.src_z});
    end
  end

  laq_norm u_norm_dir (
    .clk (clk), .en (en), .v_i (d_r), .u_o (u1), .nz_o (nz1)
  );

  // dot and cross products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) pf_r[i] <= fwd_r[i] * u1[i];
      pc_r[0] <= fwd_r[1] * u1[2];
      pc_r[1] <= fwd_r[2] * u1[1];
      pc_r[2] <= fwd_r[2] * u1[0];
      pc_r[3] <= fwd_r[0] * u1[2];
      pc_r[4] <= fwd_r[0] * u1[1];
      pc_r[5] <= fwd_r[1] * u1[0];
      nz_t1_r <= nz1;
      dsum_r  <= 34'(pf_r[0]) + 34'(pf_r[1]) + 34'(pf_r[2]);
      cr_r[0] <= DW'(pc_r[0]) - DW'(pc_r[1]);
      cr_r[1] <= DW'(pc_r[2]) - DW'(pc_r[3]);
      cr_r[2] <= DW'(pc_r[4]) - DW'(pc_r[5]);
      nz_t2_r <= nz_t1_r;
    end
  end

  laq_norm u_norm_axis (
    .clk (clk), .en (en), .v_i (cr_r), .u_o (ax), .nz_o (nz2)
  );

  // dot to Q2.14, halves away from zero
  always_comb begin
    dmag = dsum_r[33] ? 34'(-dsum_r) : 34'(dsum_r);
    dm2  = 20'((dmag + 34'(1 << (QF-1))) >> QF);
  end

  always_comb begin
    dp  = 21'(dot_r) + 21'(ONE);
    dn  = 21'(dot_r) - 21'(ONE);
    dpa = dp[20] ? 21'(-dp) : 21'(dp);
    dna = dn[20] ? 21'(-dn) : 21'(dn);
    if (dot_r > DOT_ONE)       c_nxt = 16'(ONE);
    else if (dot_r < -DOT_ONE) c_nxt = -16'(ONE);
    else                       c_nxt = 16'(dot_r);
    opc = 16'(ONE) + c_nxt;
    omc = 16'(ONE) - c_nxt;
    fl_nxt      = '0;
    fl_nxt.nz   = nz_t3_r;
    fl_nxt.opp  = dpa < 21'(tol_r);
    fl_nxt.ali  = dna < 21'(tol_r);
    fl_nxt.cpos = dot_r > 20'sd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot_r      <= dsum_r[33] ? -$signed(dm2) : $signed(dm2);
      nz_t3_r    <= nz_t2_r;
      fl_r       <= fl_nxt;
      xw_r       <= (2*RTW)'(opc) << (QF-1);
      xs_r       <= (2*RTW)'(omc) << (QF-1);
      fl_ln_r[0] <= fl_r;
      for (int k = 1; k < RTW; k++) fl_ln_r[k] <= fl_ln_r[k-1];
    end
  end

  assign wx[0] = xw_r;
  assign wr[0] = '0;
  assign wq[0] = '0;
  assign sx[0] = xs_r;
  assign sr[0] = '0;
  assign sq[0] = '0;

  for (genvar c = 0; c < RTW; c++) begin : g_root
    laq_sqrt_cell #(.RW(RTW)) u_wcell (
      .clk (clk), .en (en),
      .x_i (wx[c]),   .r_i (wr[c]),   .q_i (wq[c]),
      .x_o (wx[c+1]), .r_o (wr[c+1]), .q_o (wq[c+1])
    );
    laq_sqrt_cell #(.RW(RTW)) u_scell (
      .clk (clk), .en (en),
      .x_i (sx[c]),   .r_i (sr[c]),   .q_i (sq[c]),
      .x_o (sx[c+1]), .r_o (sr[c+1]), .q_o (sq[c+1])
    );
  end

  // round the half-angle roots to nearest: remainder above root means up
  always_comb begin
    side_nxt   = fl_ln_r[RTW-1];
    side_nxt.w = (wr[RTW] > (RTW+2)'(wq[RTW])) ? wq[RTW] + 1'b1 : wq[RTW];
    side_nxt.s = (sr[RTW] > (RTW+2)'(sq[RTW])) ? sq[RTW] + 1'b1 : sq[RTW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r  <= side_nxt;
      sd_r[0] <= side_r;
      for (int k = 1; k < SIDE_DLY; k++) sd_r[k] <= sd_r[k-1];
    end
  end

  assign sd_out = sd_r[SIDE_DLY-1];

  always_comb begin
    if (!sd_out.nz)       code_nxt = CODE_DEGEN;
    else if (sd_out.opp)  code_nxt = CODE_OPPOSITE;
    else if (sd_out.ali)  code_nxt = CODE_ALIGNED;
    else if (!nz2)        code_nxt = sd_out.cpos ? CODE_ALIGNED : CODE_OPPOSITE;
    else                  code_nxt = CODE_GENERAL;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) pq_r[i] <= ax[i] * $signed({1'b0, sd_out.s});
      w_p_r    <= sd_out.w;
      code_p_r <= code_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pmag[i] = pq_r[i][31] ? 32'(-pq_r[i]) : 32'(pq_r[i]);
      pm2[i]  = UW'((pmag[i] + 32'(1 << (QF-1))) >> QF);
    end
    unique case (code_p_r)
      CODE_GENERAL: begin
        qv_nxt[0] = $signed(UW'(w_p_r));
        for (int i = 0; i < 3; i++) begin
          qv_nxt[i+1] = pq_r[i][31] ? -$signed(pm2[i]) : $signed(pm2[i]);
        end
      end
      CODE_OPPOSITE: begin
        qv_nxt[0] = '0;
        for (int i = 0; i < 3; i++) qv_nxt[i+1] = up_r[i];
      end
      default: begin
        qv_nxt[0] = 16'(ONE);
        for (int i = 0; i < 3; i++) qv_nxt[i+1] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qv_r     <= qv_nxt;
      code_o_r <= code_p_r;
    end
  end

  assign out_ch.valid     = v_r[TOTAL_LAT-1];
  assign out_ch.quat_w    = qv_r[0];
  assign out_ch.quat_x    = qv_r[1];
  assign out_ch.quat_y    = qv_r[2];
  assign out_ch.quat_z    = qv_r[3];
  assign out_ch.case_code = code_o_r;

endmodule
